>>> sv/bmpk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binomial-mod-prime block.
// No dependencies; imported by bmpk_modmul, binomial_mod_prime_small_k and the testbench.
package bmpk_pkg;

    // Residue width and field widths
    localparam int PW = 30;
    localparam int NW = 31;
    localparam int KW = 7;

    // The prime and Fermat exponent
    localparam logic [PW-1:0] PRIME_P   = 30'd1000000007;
    localparam logic [PW-1:0] P_MINUS_2 = 30'd1000000005;

    // Barrett constant floor(2^60 / P), fits in 31 bits
    localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'(PRIME_P);
    localparam logic [30:0] MU      = MU_WIDE[30:0];

    // Modular multiplier request and response
    typedef struct packed {
        logic          start;
        logic [PW-1:0] a;
        logic [PW-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] value;
    } mm_rsp_t;

endpackage

>>> sv/bmpk_modmul.sv
`timescale 1ns / 1ps
// Shared modular multiplier: a*b mod P by Barrett reduction, five pipeline steps.
// Depends on bmpk_pkg. Operands must already be below P.
module bmpk_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  bmpk_pkg::mm_req_t req,
    output bmpk_pkg::mm_rsp_t rsp
);
    import bmpk_pkg::*;

    logic [3:0]        stage_v_reg;
    logic [2*PW-1:0]   x_reg;
    logic [61:0]       t_reg;
    logic [31:0]       xl1_reg;
    logic [31:0]       xl2_reg;
    logic [31:0]       qp_reg;
    logic [31:0]       r_reg;
    logic              done_reg;
    logic [PW-1:0]     value_reg;

    logic [2*PW-1:0]   prod_w;
    logic [61:0]       t_w;
    logic [60:0]       qp_w;
    logic [31:0]       r_w;
    logic [31:0]       fix_w;

    // Product, quotient estimate, quotient times P, remainder
    assign prod_w = req.a * req.b;
    assign t_w    = x_reg[2*PW-1:29] * MU;
    assign qp_w   = t_reg[61:31] * PRIME_P;
    assign r_w    = xl2_reg - qp_reg;

    // Estimate is at most two short, so remainder is below 3P
    always_comb
    begin
        priority if (r_reg >= 32'(2 * PRIME_P))
            fix_w = r_reg - 32'(2 * PRIME_P);
        else if (r_reg >= 32'(PRIME_P))
            fix_w = r_reg - 32'(PRIME_P);
        else
            fix_w = r_reg;
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            stage_v_reg <= {stage_v_reg[2:0], req.start};
            done_reg    <= stage_v_reg[3];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg     <= prod_w;
        t_reg     <= t_w;
        xl1_reg   <= x_reg[31:0];
        xl2_reg   <= xl1_reg;
        qp_reg    <= qp_w[31:0];
        r_reg     <= r_w;
        value_reg <= fix_w[PW-1:0];
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

`ifndef SYNTHESIS
    a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.value < PRIME_P))
        else $error("modmul result not reduced");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (stage_v_reg == '0 && !done_reg))
        else $error("modmul started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done)
        else $error("modmul done held for more than one cycle");
`endif

endmodule

>>> sv/binomial_mod_prime_small_k.sv
`timescale 1ns / 1ps
// Top level: C(n,k) mod 1000000007 with an inverse-factorial table built after reset.
// Depends on bmpk_pkg and bmpk_modmul.
//
// Usage:
//   Input stream s_axis carries one request (n, k); output stream m_axis carries
//   C(n,k) mod P. One result per request, in order.
//   After reset the block builds the table of inverse factorials 0..K_MAX: the
//   factorial of K_MAX, its inverse by square-and-multiply on P-2, then the
//   downward fill. s_axis_tready stays low during this.
//   Each modular multiplication holds the sequencer through issue, five steps
//   in the shared Barrett multiplier, and capture. k beyond K_MAX or k > n
//   gives 0 with no multiplication. The next request is taken the cycle after
//   the result is loaded into the output register.
//   If the receiver stalls, the result is held in the output register and a
//   finished computation waits until that register is free.
module binomial_mod_prime_small_k #(
    parameter int K_MAX = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [30:0] top_n, [37:31] choose_k, [39:38] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [29:0] binom_mod, [31:30] zero
);
    import bmpk_pkg::*;

    localparam int IW = $clog2(K_MAX + 2);
    localparam int TW = (K_MAX + 1 > 1) ? $clog2(K_MAX + 1) : 1;

    typedef enum logic [3:0] {
        ST_FACT, ST_POW_A, ST_POW_S, ST_FILL,
        ST_IDLE, ST_PREP, ST_PROD, ST_INV, ST_OUT
    } state_t;

    state_t         state_reg;
    logic           wait_reg;
    logic           mul_start_reg;
    logic [PW-1:0]  op_a_reg;
    logic [PW-1:0]  op_b_reg;
    logic [PW-1:0]  acc_reg;
    logic [PW-1:0]  sq_reg;
    logic [PW-1:0]  exp_reg;
    logic [IW-1:0]  i_reg;
    logic [NW-1:0]  n_reg;
    logic [KW-1:0]  k_reg;
    logic [KW-1:0]  j_reg;
    logic [PW-1:0]  f_reg;
    logic [PW-1:0]  res_reg;
    logic           out_valid_reg;
    logic [PW-1:0]  out_data_reg;

    logic           we_reg;
    logic [TW-1:0]  waddr_reg;
    logic [PW-1:0]  wdata_reg;
    logic [PW-1:0]  inv_rd_reg;
    logic [PW-1:0]  inv_mem [K_MAX+1];

    logic           mul_start_next;
    logic           we_next;
    logic           out_valid_next;

    mm_req_t        mul_req;
    mm_rsp_t        mul_rsp;

    logic [NW-1:0]  in_n;
    logic [KW-1:0]  in_k;
    logic           in_acc;
    logic [NW-1:0]  n_red_w;

    assign in_n   = s_axis_tdata[30:0];
    assign in_k   = s_axis_tdata[37:31];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

    // Shared multiplier
    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = op_a_reg;
    assign mul_req.b     = op_b_reg;

    bmpk_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // n mod P; n is below 3P
    always_comb
    begin
        priority if (n_reg >= NW'(2 * PRIME_P))
            n_red_w = n_reg - NW'(2 * PRIME_P);
        else if (n_reg >= NW'(PRIME_P))
            n_red_w = n_reg - NW'(PRIME_P);
        else
            n_red_w = n_reg;
    end

    // Next values of the multiplier issue, table write and output valid flags
    always_comb
    begin
        mul_start_next = 1'b0;
        we_next        = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_FACT:
                mul_start_next = !wait_reg && (i_reg <= IW'(K_MAX));
            ST_POW_A:
            begin
                mul_start_next = !wait_reg && (exp_reg != '0) && exp_reg[0];
                we_next        = !wait_reg && (exp_reg == '0);
            end
            ST_POW_S, ST_INV:
                mul_start_next = !wait_reg;
            ST_FILL:
            begin
                mul_start_next = !wait_reg;
                we_next        = wait_reg && mul_rsp.done;
            end
            ST_PROD:
                mul_start_next = !wait_reg && (j_reg != '0);
            // a held result stays valid, a free register is loaded
            ST_OUT:
                out_valid_next = 1'b1;
            default:
                mul_start_next = 1'b0;
        endcase
    end

    // Inverse factorial table
    always_ff @(posedge clk)
    begin
        if (we_reg)
            inv_mem[waddr_reg] <= wdata_reg;
        if (state_reg == ST_PREP)
            inv_rd_reg <= inv_mem[TW'(k_reg)];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FACT;
            wait_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            we_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= IW'(2);
            acc_reg       <= PW'(1);
        end
        else
        begin
            mul_start_reg <= mul_start_next;
            we_reg        <= we_next;
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                // factorial of K_MAX
                ST_FACT:
                begin
                    if (!wait_reg)
                    begin
                        if (i_reg > IW'(K_MAX))
                        begin
                            sq_reg    <= acc_reg;
                            acc_reg   <= PW'(1);
                            exp_reg   <= P_MINUS_2;
                            state_reg <= ST_POW_A;
                        end
                        else
                        begin
                            op_a_reg <= acc_reg;
                            op_b_reg <= PW'(i_reg);
                            wait_reg <= 1'b1;
                        end
                    end
                    else if (mul_rsp.done)
                    begin
                        acc_reg  <= mul_rsp.value;
                        i_reg    <= i_reg + 1'b1;
                        wait_reg <= 1'b0;
                    end
                end

                // exponent bit: multiply into acc if set; at zero, write entry K_MAX
                ST_POW_A:
                begin
                    if (!wait_reg)
                    begin
                        if (exp_reg == '0)
                        begin
                            waddr_reg <= TW'(K_MAX);
                            wdata_reg <= acc_reg;
                            sq_reg    <= acc_reg;
                            i_reg     <= IW'(K_MAX);
                            state_reg <= ST_FILL;
                        end
                        else if (exp_reg[0])
                        begin
                            op_a_reg <= acc_reg;
                            op_b_reg <= sq_reg;
                            wait_reg <= 1'b1;
                        end
                        else
                            state_reg <= ST_POW_S;
                    end
                    else if (mul_rsp.done)
                    begin
                        acc_reg   <= mul_rsp.value;
                        wait_reg  <= 1'b0;
                        state_reg <= ST_POW_S;
                    end
                end

                // square the base
                ST_POW_S:
                begin
                    if (!wait_reg)
                    begin
                        op_a_reg <= sq_reg;
                        op_b_reg <= sq_reg;
                        wait_reg <= 1'b1;
                    end
                    else if (mul_rsp.done)
                    begin
                        sq_reg    <= mul_rsp.value;
                        exp_reg   <= exp_reg >> 1;
                        wait_reg  <= 1'b0;
                        state_reg <= ST_POW_A;
                    end
                end

                // downward fill, sq_reg holds the last entry written
                ST_FILL:
                begin
                    if (!wait_reg)
                    begin
                        op_a_reg <= PW'(i_reg);
                        op_b_reg <= sq_reg;
                        wait_reg <= 1'b1;
                    end
                    else if (mul_rsp.done)
                    begin
                        sq_reg    <= mul_rsp.value;
                        waddr_reg <= TW'(i_reg - 1'b1);
                        wdata_reg <= mul_rsp.value;
                        i_reg     <= i_reg - 1'b1;
                        wait_reg  <= 1'b0;
                        if (i_reg == IW'(1))
                            state_reg <= ST_IDLE;
                    end
                end

                // take a request
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        n_reg <= in_n;
                        k_reg <= in_k;
                        if (32'(in_k) > 32'(K_MAX) || NW'(in_k) > in_n)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                            state_reg <= ST_PREP;
                    end
                end

                // first factor and table read
                ST_PREP:
                begin
                    f_reg     <= n_red_w[PW-1:0];
                    j_reg     <= k_reg;
                    acc_reg   <= PW'(1);
                    state_reg <= ST_PROD;
                end

                // falling product, factor steps down modulo P
                ST_PROD:
                begin
                    if (!wait_reg)
                    begin
                        if (j_reg == '0)
                            state_reg <= ST_INV;
                        else
                        begin
                            op_a_reg <= acc_reg;
                            op_b_reg <= f_reg;
                            wait_reg <= 1'b1;
                        end
                    end
                    else if (mul_rsp.done)
                    begin
                        acc_reg  <= mul_rsp.value;
                        f_reg    <= (f_reg == '0) ? PRIME_P - 1'b1 : f_reg - 1'b1;
                        j_reg    <= j_reg - 1'b1;
                        wait_reg <= 1'b0;
                    end
                end

                // times inverse factorial of k
                ST_INV:
                begin
                    if (!wait_reg)
                    begin
                        op_a_reg <= acc_reg;
                        op_b_reg <= inv_rd_reg;
                        wait_reg <= 1'b1;
                    end
                    else if (mul_rsp.done)
                    begin
                        res_reg   <= mul_rsp.value;
                        wait_reg  <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end

                // hand over to the output register
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && NW'(in_k) > in_n) |=> (state_reg == ST_OUT && res_reg == '0))
        else $error("k above n did not give zero");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> wait_reg)
        else $error("multiplier result with no request pending");
    a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:0] < PRIME_P && m_axis_tdata[31:30] == 2'b00))
        else $error("result not reduced modulo P");
`endif

endmodule

>>> test/binomial_mod_prime_small_k_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for binomial_mod_prime_small_k: a directed table of requests,
// then random requests, each checked against a typed value or an in-bench model of C(n,k)
// mod P, with random idling on both sides. Depends on bmpk_pkg and binomial_mod_prime_small_k.
module binomial_mod_prime_small_k_test;

    import bmpk_pkg::*;

    localparam int K_MAX        = 100;
    localparam int RANDOM_COUNT = 630;
    localparam int QUIET_FROM   = 560;   // random requests from here on go without idling
    localparam int PAUSE_AT     = 300;   // sender waits for an empty pipe here
    localparam int HOLD_AFTER   = 40;    // long receiver hold-off starts after this many requests
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    // Directed request: typed expectation used only where has_value is set
    typedef struct packed {
        logic [NW-1:0] n;
        logic [KW-1:0] k;
        bit            has_value;
        logic [PW-1:0] value;
    } binom_row_t;

    localparam int ROW_COUNT = 23;
    localparam binom_row_t BINOM_ROWS [0:ROW_COUNT-1] = '{
        '{31'd0,          7'd0,   1'b1, 30'd1},
        '{31'd2147483647, 7'd0,   1'b1, 30'd1},
        '{31'd0,          7'd1,   1'b1, 30'd0},           // k exceeds n
        '{31'd5,          7'd6,   1'b1, 30'd0},
        '{31'd100,        7'd101, 1'b1, 30'd0},           // k beyond the table
        '{31'd2147483647, 7'd127, 1'b1, 30'd0},
        '{31'd0,          7'd127, 1'b1, 30'd0},
        '{31'd1000000007, 7'd1,   1'b1, 30'd0},           // factor is P itself
        '{31'd1000000010, 7'd10,  1'b1, 30'd0},           // window crosses P
        '{31'd2000000014, 7'd1,   1'b1, 30'd0},           // factor is 2P
        '{31'd1000000106, 7'd100, 1'b1, 30'd0},           // last factor is P
        '{31'd1000000107, 7'd100, 1'b0, 30'd0},           // window just above P
        '{31'd5,          7'd2,   1'b1, 30'd10},
        '{31'd10,         7'd5,   1'b1, 30'd252},
        '{31'd100,        7'd100, 1'b1, 30'd1},
        '{31'd1,          7'd1,   1'b1, 30'd1},
        '{31'd1,          7'd100, 1'b1, 30'd0},
        '{31'd1000000006, 7'd1,   1'b1, 30'd1000000006},
        '{31'd2147483647, 7'd1,   1'b0, 30'd0},
        '{31'd2147483647, 7'd100, 1'b0, 30'd0},
        '{31'd50,         7'd25,  1'b0, 30'd0},
        '{31'd127,        7'd64,  1'b0, 30'd0},
        '{31'd1073741824, 7'd3,   1'b0, 30'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // [30:0] top_n, [37:31] choose_k, [39:38] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [29:0] binom_mod, [31:30] zero

    logic [PW-1:0] inv_fact [0:K_MAX];
    logic [PW-1:0] expected_binom [$];
    int            mismatches = 0;
    int            accepted_count = 0;
    bit            quiet_tail = 1'b0;

    binomial_mod_prime_small_k #(.K_MAX(K_MAX)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Modular arithmetic for the prediction
    function automatic logic [PW-1:0] mul_mod_p(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned p;
        p = longint'(PRIME_P);
        return PW'(((a % p) * (b % p)) % p);
    endfunction

    function automatic logic [PW-1:0] pow_mod_p(input logic [PW-1:0] base,
                                                input logic [PW-1:0] expo);
        logic [PW-1:0] acc;
        logic [PW-1:0] sq;
        logic [PW-1:0] e;
        acc = PW'(1);
        sq  = base;
        e   = expo;
        while (e != 0) begin
            if (e[0])
                acc = mul_mod_p(acc, sq);
            sq = mul_mod_p(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Inverse factorials: top one by Fermat, then downward
    function automatic void build_inv_fact();
        logic [PW-1:0] fact;
        fact = PW'(1);
        for (int i = 2; i <= K_MAX; i++)
            fact = mul_mod_p(fact, i);
        inv_fact[K_MAX] = pow_mod_p(fact, P_MINUS_2);
        for (int i = K_MAX; i >= 1; i--)
            inv_fact[i-1] = mul_mod_p(i, inv_fact[i]);
    endfunction

    function automatic logic [PW-1:0] predict_binom(input logic [NW-1:0] n,
                                                    input logic [KW-1:0] k);
        logic [PW-1:0] acc;
        if (k > K_MAX || k > n)
            return '0;
        acc = PW'(1);
        for (int j = 0; j < k; j++)
            acc = mul_mod_p(acc, longint'(n) - j);
        return mul_mod_p(acc, inv_fact[k]);
    endfunction

    // Offer one request, optionally after an idle burst; returns once it is accepted
    task automatic send_request(input logic [NW-1:0] n, input logic [KW-1:0] k,
                                input bit has_value, input logic [PW-1:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, k, n};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_binom.push_back(has_value ? value : predict_binom(n, k));
        accepted_count++;
    endtask

    // Random request, weighted towards the awkward corners
    task automatic send_random_request();
        logic [NW-1:0] n;
        logic [KW-1:0] k;
        int            pick;
        pick = $urandom_range(0, 99);
        k = ($urandom_range(0, 1) == 0) ? KW'($urandom_range(0, 16)) : KW'($urandom_range(0, K_MAX));
        if (pick < 8) begin
            n = NW'($urandom());
            k = KW'($urandom_range(K_MAX + 1, 127));
        end else if (pick < 18) begin
            n = NW'($urandom_range(0, K_MAX - 1));
            k = KW'($urandom_range(n + 1, K_MAX));
        end else if (pick < 32) begin
            n = NW'(longint'(PRIME_P) * $urandom_range(1, 2) + $urandom_range(0, 120));
        end else if (pick < 42) begin
            n = NW'(31'h7FFF_FFFF - $urandom_range(0, 200));
        end else if (pick < 55) begin
            n = NW'($urandom_range(0, 300));
        end else begin
            n = NW'($urandom());
        end
        send_request(n, k, 1'b0, '0);
    endtask

    // Reset, then the stimulus and the final verdict
    initial begin
        build_inv_fact();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < ROW_COUNT; r++)
            send_request(BINOM_ROWS[r].n, BINOM_ROWS[r].k, BINOM_ROWS[r].has_value,
                         BINOM_ROWS[r].value);

        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i == PAUSE_AT) begin
                s_axis_tvalid <= 1'b0;
                while (expected_binom.size() != 0)
                    @(posedge clk);
            end
            if (i == QUIET_FROM)
                quiet_tail = 1'b1;
            send_random_request();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_binom.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Result check against the oldest outstanding request
    always @(posedge clk) begin
        logic [PW-1:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_binom.size() == 0) begin
                $error("binom_mod: no request outstanding, actual %0d", m_axis_tdata[PW-1:0]);
                mismatches++;
            end else begin
                want = expected_binom.pop_front();
                if (m_axis_tdata[PW-1:0] !== want) begin
                    $error("binom_mod: expected %0d, actual %0d", want, m_axis_tdata[PW-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[31:PW] !== '0) begin
                    $error("tdata pad: expected 0, actual %0d", m_axis_tdata[31:PW]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
sv/bmpk_pkg.sv
sv/bmpk_modmul.sv
sv/binomial_mod_prime_small_k.sv
test/binomial_mod_prime_small_k_test.sv
